/* rtl/rrts_pkg.sv */
// Shared types and constants of the round-robin time-slice scheduler.
package rrts_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int ID_W = 4;
	localparam int BURST_W = 16;
	localparam int QUANTUM_W = 8;
	localparam int TICK_W = 32;
	localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd4;
	localparam logic [QUANTUM_W-1:0] SLICE_MAX = 8'hFF;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 48;

	typedef enum logic {
		MODE_ARRIVAL = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef struct packed {
		logic [ID_W-1:0] task_id;
		logic [BURST_W-1:0] remaining;
		logic started;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic rotate;
		logic run;
	} cell_ctrl_t;

endpackage

/* rtl/rrts_cell.sv */
// One queue cell: holds a task entry, loads arrivals and takes its neighbor's when the queue moves.
module rrts_cell #(
	parameter int CW = 5,
	parameter int IDX = 0
) (
	input logic clk,
	input rrts_pkg::cell_ctrl_t ctrl,
	input logic [CW-1:0] count,
	input rrts_pkg::entry_t arr_entry,
	input rrts_pkg::entry_t head_entry,
	input rrts_pkg::entry_t next_entry,
	output rrts_pkg::entry_t entry
);
	import rrts_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	entry_t entry_q;
	entry_t entry_d;
	logic [CW-1:0] last_pos;

	assign last_pos = count - CW'(1);

	always_comb begin
		entry_d = entry_q;
		if (ctrl.load && (count == IDX_C)) begin
			entry_d = arr_entry;
		end else if (ctrl.shift) begin
			if (ctrl.rotate && (last_pos == IDX_C)) begin
				entry_d = head_entry;
			end else begin
				entry_d = next_entry;
			end
		end
		if (ctrl.run && (IDX == 0)) begin
			entry_d.remaining = entry_d.remaining - BURST_W'(1);
			entry_d.started = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

/* rtl/round_robin_time_slice_scheduler_top.sv */
// Top level of the round-robin time-slice scheduler.
// Input transfers on the s_axis group carry either a task arrival (tuser low)
// with its identifier and burst length, or one time tick (tuser high).
// An arrival enters the queue tail and gives no result; an arrival into a full
// queue is dropped. A tick retires a finished head task, or rotates a head that
// has used its quantum to the tail, then runs the head for one unit, and gives
// one result on the m_axis group in the cycle after its transfer.
// The queue is a row of cells; cell zero is always the head, and every cell
// takes its neighbor's entry when the head leaves.
// One item is accepted per cycle while the result register is free or is being
// drained in the same cycle.
// The cfg channel writes the quantum and is always ready; write it only while
// the block is idle.
// Reset empties the queue, clears the tick counter and slice count, and sets
// the quantum to four. When the receiver stalls, the result is held and input
// transfers stop until it is taken.
module round_robin_time_slice_scheduler_top #(
	parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: task_id[3:0], burst_time[19:4], zero fill.
	input logic [rrts_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// Fields from bit 0: mode.
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// Fields from bit 0: tick_time[31:0], run_valid[32], run_id[36:33],
	// first_run[37], done_valid[38], done_id[42:39], queue_empty[43], zero fill.
	output logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rrts_pkg::QUANTUM_W-1:0] cfg_data
);
	import rrts_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] FULL_C = CW'(MAX_TASKS);

	logic [CW-1:0] count_q;
	logic [QUANTUM_W-1:0] slice_q;
	logic [QUANTUM_W-1:0] quantum_q;
	logic [TICK_W-1:0] tick_q;
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	entry_t cells [MAX_TASKS];
	entry_t arr_entry;
	entry_t new_head;
	cell_ctrl_t ctrl;

	logic accept;
	logic is_tick;
	logic is_arrival;
	logic has_task;
	logic pop;
	logic [CW-1:0] count_after;
	logic [CW-1:0] count_d;
	logic [QUANTUM_W-1:0] slice_mid;
	logic [QUANTUM_W-1:0] slice_d;
	logic [OUT_DATA_W-1:0] result;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign is_tick = accept && (mode_t'(s_axis_tuser) == MODE_TICK);
	assign is_arrival = accept && (mode_t'(s_axis_tuser) == MODE_ARRIVAL);
	assign has_task = count_q != '0;

	assign arr_entry.task_id = s_axis_tdata[ID_W-1:0];
	assign arr_entry.remaining = s_axis_tdata[ID_W+BURST_W-1:ID_W];
	assign arr_entry.started = 1'b0;

	always_comb begin
		pop = is_tick && has_task && (cells[0].remaining == '0);
		ctrl.rotate = is_tick && has_task && !pop && (slice_q >= quantum_q);
		ctrl.shift = pop || ctrl.rotate;
		ctrl.load = is_arrival && (count_q != FULL_C);
		count_after = pop ? count_q - CW'(1) : count_q;
		if (!ctrl.shift) begin
			new_head = cells[0];
		end else if (ctrl.rotate && (count_q == CW'(1))) begin
			new_head = cells[0];
		end else begin
			new_head = cells[1];
		end
		ctrl.run = is_tick && (count_after != '0) && (new_head.remaining != '0);
		slice_mid = ctrl.shift ? '0 : slice_q;
		slice_d = (ctrl.run && (slice_mid != SLICE_MAX)) ? slice_mid + QUANTUM_W'(1) : slice_mid;
		count_d = ctrl.load ? count_q + CW'(1) : count_after;
		result = '0;
		result[TICK_W-1:0] = tick_q;
		result[32] = ctrl.run;
		result[36:33] = ctrl.run ? new_head.task_id : '0;
		result[37] = ctrl.run && !new_head.started;
		result[38] = pop;
		result[42:39] = pop ? cells[0].task_id : '0;
		result[43] = count_after == '0;
	end

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		entry_t next_entry;
		if (i == MAX_TASKS - 1) begin : g_last
			assign next_entry = cells[i];
		end else begin : g_mid
			assign next_entry = cells[i+1];
		end
		rrts_cell #(
			.CW(CW),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.count(count_q),
			.arr_entry(arr_entry),
			.head_entry(cells[0]),
			.next_entry(next_entry),
			.entry(cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			slice_q <= '0;
			tick_q <= '0;
			quantum_q <= QUANTUM_RST;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			slice_q <= slice_d;
			if (is_tick) begin
				tick_q <= tick_q + TICK_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_data;
			end
			if (is_tick) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("queue fill count exceeds capacity");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick |=> m_axis_tvalid && (m_axis_tdata[TICK_W-1:0] == $past(tick_q)))
		else $error("tick transfer did not produce its result");

	a_arrival_count: assert property (@(posedge clk) disable iff (!arst_n)
		(is_arrival && (count_q != FULL_C)) |=> count_q == $past(count_q) + CW'(1))
		else $error("arrival did not enter the queue");

endmodule
